>>> design/sorted_set_engine_assert.svh
// Assertion macros used by the sorted set engine datapath.
`ifndef SORTED_SET_ENGINE_ASSERT_SVH
`define SORTED_SET_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle property check, disabled during reset.
`define SSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Next-cycle implication, disabled during reset.
`define SSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSE_ASSERT(lbl, clk, rst, prop, msg)
`define SSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/sse_pkg.sv
// Types and codes shared by the sorted set engine modules.
package sse_pkg;

   typedef enum logic [1:0] {
      ACT_DELETE = 2'd0,
      ACT_FIND   = 2'd1,
      ACT_INSERT = 2'd2,
      ACT_LIST   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      RSP_INSERTED  = 4'd0,
      RSP_DUPLICATE = 4'd1,
      RSP_FULL      = 4'd2,
      RSP_FOUND     = 4'd3,
      RSP_ABSENT    = 4'd4,
      RSP_DELETED   = 4'd5,
      RSP_DEL_MISS  = 4'd6,
      RSP_ENTRY     = 4'd7,
      RSP_EMPTY     = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_APPLY = 2'd1,
      ST_LIST  = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      OP_NOP       = 2'd0,
      OP_CAPTURE   = 2'd1,
      OP_APPLY     = 2'd2,
      OP_LIST_STEP = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic list_last;
   } stat_type;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 4;
   localparam int unsigned ACTION_W = 2;

endpackage

>>> design/sse_ctrl.sv
// Sequencer for the sorted set engine: accepts requests and steps the datapath.
module sse_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sse_pkg::ACTION_W-1:0] req_tuser,
   input  sse_pkg::stat_type           stat,
   output sse_pkg::cmd_type            cmd
);

   sse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.op     = sse_pkg::OP_NOP;
      case (state_ff)
         sse_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = sse_pkg::OP_CAPTURE;
               if (sse_pkg::action_type'(req_tuser) == sse_pkg::ACT_LIST) begin
                  state_in = sse_pkg::ST_LIST;
               end else begin
                  state_in = sse_pkg::ST_APPLY;
               end
            end
         end
         sse_pkg::ST_APPLY: begin
            if (stat.out_free) begin
               cmd.op   = sse_pkg::OP_APPLY;
               state_in = sse_pkg::ST_IDLE;
            end
         end
         sse_pkg::ST_LIST: begin
            if (stat.out_free) begin
               cmd.op = sse_pkg::OP_LIST_STEP;
               if (stat.list_last) begin
                  state_in = sse_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sse_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/sse_dp.sv
// Datapath: sorted entry cells, compare vectors, count and output register.
`include "sorted_set_engine_assert.svh"
module sse_dp #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sse_pkg::cmd_type             cmd,
   output sse_pkg::stat_type            stat,
   input  logic [sse_pkg::ACTION_W-1:0] req_tuser,
   input  logic [sse_pkg::VALUE_W-1:0]  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sse_pkg::VALUE_W-1:0]  rsp_tdata,
   output logic [sse_pkg::STATUS_W-1:0] rsp_tuser,
   output logic                         rsp_tlast
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic signed [sse_pkg::VALUE_W-1:0] entry_ff [CAPACITY];
   logic signed [sse_pkg::VALUE_W-1:0] entry_in [CAPACITY];
   logic [CW-1:0]                      used_ff, used_in, idx_ff, idx_in, used_m1;
   sse_pkg::action_type                action_ff;
   logic signed [sse_pkg::VALUE_W-1:0] value_ff, req_value;
   logic [CAPACITY-1:0]                lt_ff, lt_in, eq_ff, eq_in;
   logic                               hit, full, load;
   logic                               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   sse_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [sse_pkg::VALUE_W-1:0]        rsp_item_ff, rsp_item_in;

   assign req_value = $signed(req_tdata);
   assign hit       = |eq_ff;
   assign full      = (used_ff == CW'(CAPACITY));
   assign used_m1   = used_ff - 1'b1;

   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.list_last = (used_ff == '0) || (idx_ff == used_m1);

   // per-cell compare against the incoming value, masked to occupied cells
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (CW'(i) < used_ff) && (entry_ff[i] < req_value);
         eq_in[i] = (CW'(i) < used_ff) && (entry_ff[i] == req_value);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entry_in[i] = entry_ff[i];
      end
      used_in       = used_ff;
      idx_in        = idx_ff;
      load          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      case (cmd.op)
         sse_pkg::OP_APPLY: begin
            load        = 1'b1;
            rsp_item_in = value_ff;
            rsp_last_in = 1'b1;
            case (action_ff)
               sse_pkg::ACT_INSERT: begin
                  if (full) begin
                     rsp_status_in = sse_pkg::RSP_FULL;
                  end else if (hit) begin
                     rsp_status_in = sse_pkg::RSP_DUPLICATE;
                  end else begin
                     rsp_status_in = sse_pkg::RSP_INSERTED;
                     used_in       = used_ff + 1'b1;
                     // cells at or above the slot move up; the slot takes the value
                     if (!lt_ff[0]) begin
                        entry_in[0] = value_ff;
                     end
                     for (int i = 1; i < CAPACITY; i++) begin
                        if (!lt_ff[i]) begin
                           entry_in[i] = lt_ff[i-1] ? value_ff : entry_ff[i-1];
                        end
                     end
                  end
               end
               sse_pkg::ACT_DELETE: begin
                  if (hit) begin
                     rsp_status_in = sse_pkg::RSP_DELETED;
                     used_in       = used_m1;
                     for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (!lt_ff[i]) begin
                           entry_in[i] = entry_ff[i+1];
                        end
                     end
                  end else begin
                     rsp_status_in = sse_pkg::RSP_DEL_MISS;
                  end
               end
               sse_pkg::ACT_FIND: begin
                  rsp_status_in = hit ? sse_pkg::RSP_FOUND : sse_pkg::RSP_ABSENT;
               end
               default: begin
                  rsp_status_in = sse_pkg::RSP_EMPTY;
               end
            endcase
         end
         sse_pkg::OP_LIST_STEP: begin
            load = 1'b1;
            if (used_ff == '0) begin
               rsp_status_in = sse_pkg::RSP_EMPTY;
               rsp_item_in   = '0;
               rsp_last_in   = 1'b1;
            end else begin
               rsp_status_in = sse_pkg::RSP_ENTRY;
               rsp_item_in   = entry_ff[0];
               rsp_last_in   = stat.list_last;
               idx_in        = stat.list_last ? '0 : idx_ff + 1'b1;
               // rotate the occupied cells down by one; head wraps to the top
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  entry_in[i] = (CW'(i) == used_m1) ? entry_ff[0] : entry_ff[i+1];
               end
               entry_in[CAPACITY-1] = entry_ff[0];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.op == sse_pkg::OP_CAPTURE) begin
         action_ff <= sse_pkg::action_type'(req_tuser);
         value_ff  <= req_value;
         lt_ff     <= lt_in;
         eq_ff     <= eq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SSE_ASSERT(a_used_bound, clock, reset, used_ff <= CW'(CAPACITY), "set count above capacity")
   `SSE_ASSERT(a_lt_thermo, clock, reset, (cmd.op == sse_pkg::OP_APPLY) |-> (((lt_ff + 1'b1) & lt_ff) == '0), "less-than vector not contiguous")
   `SSE_ASSERT(a_eq_single, clock, reset, (cmd.op == sse_pkg::OP_APPLY) |-> $onehot0(eq_ff), "value matched more than one cell")
   `SSE_ASSERT_NEXT(a_ins_count, clock, reset, (cmd.op == sse_pkg::OP_APPLY) && (action_ff == sse_pkg::ACT_INSERT) && !full && !hit, used_ff == $past(used_ff) + 1'b1, "insert did not grow the set")

endmodule

>>> design/sorted_set_engine.sv
// Sorted set engine top level: request/response streams around controller and datapath.
// Find, insert and delete: accept, then apply once the output register is free; the
//   result is held in the output register until the receiver takes it.
// List: accept, then one response per stored entry (or one for an empty set); the
//   rotating entry row gives one entry per cycle from its head cell unless stalled.
// Reset (synchronous, active high) empties the set and drops any pending response.
module sorted_set_engine #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value (signed)
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] item (signed)
   output logic [3:0]  rsp_tuser,   // [3:0] status
   output logic        rsp_tlast
);

   // command from the sequencer, status back from the datapath
   sse_pkg::cmd_type  cmd;
   sse_pkg::stat_type stat;

   // Sequencer: one request at a time; idle state is the only accepting state.
   sse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: a row of sorted cells compared in parallel at accept time; the
   // registered compare vectors drive the insert/delete shift in the apply step.
   sse_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sim/sorted_set_engine_tb.sv
// Self-checking testbench for the sorted set engine: directed table, then phased random traffic.
`timescale 1ns / 1ps

module sorted_set_engine_tb;

   localparam int unsigned CAPACITY    = 32;
   localparam int          HALF_PERIOD = 5;
   localparam int          RESET_CYCLES = 3;
   localparam int          RANDOM_ITEMS = 450;
   localparam int          POOL_SIZE   = 40;
   localparam int          HOLD_CYCLES = 300;     // long receiver hold-off
   localparam int          DRAIN_CYCLES = 40;     // one full listing plus margin
   localparam int          CYCLE_LIMIT = 400000;  // many times the slowest legal run
   localparam int          PRINT_LIMIT = 50;

   // traffic mixes for the random phases
   localparam int PH_FILL  = 0;
   localparam int PH_MIXED = 1;
   localparam int PH_DRAIN = 2;

   typedef struct packed {
      sse_pkg::status_type status;
      logic [31:0]         item;
      logic                last;
   } reply_type;

   // one row of the directed table; typed == 0 rows are checked against the predictor
   typedef struct packed {
      sse_pkg::action_type act;
      logic [31:0]         value;
      bit                  typed;
      sse_pkg::status_type status;
      logic [31:0]         item;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] value (signed)
   logic [1:0]  req_tuser = sse_pkg::ACT_LIST; // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] item (signed)
   logic [3:0]  rsp_tuser;         // [3:0] status
   logic        rsp_tlast;

   // sideband carried with each request: a hand-typed expectation, if any
   bit                  req_typed = 1'b0;
   sse_pkg::status_type req_typed_status = sse_pkg::RSP_EMPTY;
   logic [31:0]         req_typed_item = '0;

   // predictor copy of the set
   logic signed [31:0] set_vals [CAPACITY];
   int unsigned        set_count = 0;
   reply_type          step_out [$];   // results of the last predicted request
   reply_type          reply_q [$];    // results still owed by the block

   int          mismatches = 0;
   int unsigned cycle_count = 0;
   int          burst_left = 0;
   int          hold_asked = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   logic [31:0] value_pool [POOL_SIZE];
   dir_row_type dir_tab [0:20];

   sorted_set_engine #(.CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Predictor: applies one request to the local set and fills step_out.
   function void predict_set_op(input sse_pkg::action_type act, input logic signed [31:0] v);
      int unsigned pos;
      bit          hit;
      step_out.delete();
      pos = 0;
      while (pos < set_count && set_vals[pos] < v) pos++;
      hit = (pos < set_count) && (set_vals[pos] == v);
      case (act)
         sse_pkg::ACT_DELETE: begin
            if (hit) begin
               for (int unsigned i = pos; i + 1 < set_count; i++) set_vals[i] = set_vals[i + 1];
               set_count--;
               step_out.push_back('{sse_pkg::RSP_DELETED, v, 1'b1});
            end else begin
               step_out.push_back('{sse_pkg::RSP_DEL_MISS, v, 1'b1});
            end
         end
         sse_pkg::ACT_FIND: begin
            step_out.push_back('{hit ? sse_pkg::RSP_FOUND : sse_pkg::RSP_ABSENT, v, 1'b1});
         end
         sse_pkg::ACT_INSERT: begin
            // full takes priority over duplicate
            if (set_count >= CAPACITY) begin
               step_out.push_back('{sse_pkg::RSP_FULL, v, 1'b1});
            end else if (hit) begin
               step_out.push_back('{sse_pkg::RSP_DUPLICATE, v, 1'b1});
            end else begin
               for (int unsigned i = set_count; i > pos; i--) set_vals[i] = set_vals[i - 1];
               set_vals[pos] = v;
               set_count++;
               step_out.push_back('{sse_pkg::RSP_INSERTED, v, 1'b1});
            end
         end
         default: begin
            if (set_count == 0) begin
               step_out.push_back('{sse_pkg::RSP_EMPTY, 32'h0, 1'b1});
            end else begin
               for (int unsigned i = 0; i < set_count; i++)
                  step_out.push_back('{sse_pkg::RSP_ENTRY, set_vals[i], (i + 1 == set_count)});
            end
         end
      endcase
   endfunction

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("[%0d] %s: got %h, want %h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // Scoreboard: predicts on every accepted request, checks every accepted response.
   always @(posedge clock) begin : scoreboard
      reply_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_set_op(sse_pkg::action_type'(req_tuser), req_tdata);
            if (req_typed) begin
               reply_q.push_back('{req_typed_status, req_typed_item, 1'b1});
            end else begin
               foreach (step_out[i]) reply_q.push_back(step_out[i]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, 32'h0);
            end else begin
               want = reply_q.pop_front();
               if (rsp_tuser !== want.status) report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata !== want.item) report_mismatch("item", rsp_tdata, want.item);
               if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
            end
         end
      end
   end

   // Receiver pacing: rotating stall pattern, plus a long hold-off whenever one is asked.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case ((cycle_count / 97) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= (cycle_count % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 99) < 85);
         endcase
      end
   end

   // Offers one request and holds it until accepted; then maybe a gap before the next.
   task send_req(input sse_pkg::action_type act, input logic [31:0] v, input bit typed,
                 input sse_pkg::status_type tstatus, input logic [31:0] titem);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= v;
      req_typed <= typed;
      req_typed_status <= tstatus;
      req_typed_item <= titem;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long stretch with no sender idling
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      end
   endtask

   function sse_pkg::action_type pick_action(input int phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         PH_FILL:
            return (r < 70) ? sse_pkg::ACT_INSERT :
                   (r < 80) ? sse_pkg::ACT_FIND :
                   (r < 90) ? sse_pkg::ACT_DELETE : sse_pkg::ACT_LIST;
         PH_DRAIN:
            return (r < 65) ? sse_pkg::ACT_DELETE :
                   (r < 78) ? sse_pkg::ACT_INSERT :
                   (r < 90) ? sse_pkg::ACT_FIND : sse_pkg::ACT_LIST;
         default:
            return (r < 35) ? sse_pkg::ACT_INSERT :
                   (r < 60) ? sse_pkg::ACT_DELETE :
                   (r < 85) ? sse_pkg::ACT_FIND : sse_pkg::ACT_LIST;
      endcase
   endfunction

   // Mostly values that collide with stored ones, so hits and duplicates are common.
   function logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 75 && set_count != 0) return set_vals[$urandom_range(0, set_count - 1)];
      return $urandom;
   endfunction

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("sorted_set_engine: mismatch");
      $finish;
   end

   initial begin : stimulus
      sse_pkg::action_type act;
      int                  n_random;
      int                  phase_idx;
      int                  phase_len;

      dir_tab = '{
         // empty after reset
         '{sse_pkg::ACT_LIST,   32'h0000_0000, 1'b1, sse_pkg::RSP_EMPTY,     32'h0000_0000},
         '{sse_pkg::ACT_FIND,   32'h0000_0000, 1'b1, sse_pkg::RSP_ABSENT,    32'h0000_0000},
         '{sse_pkg::ACT_DELETE, 32'h0000_0005, 1'b1, sse_pkg::RSP_DEL_MISS,  32'h0000_0005},
         // most positive
         '{sse_pkg::ACT_INSERT, 32'h7fff_ffff, 1'b1, sse_pkg::RSP_INSERTED,  32'h7fff_ffff},
         // most negative
         '{sse_pkg::ACT_INSERT, 32'h8000_0000, 1'b1, sse_pkg::RSP_INSERTED,  32'h8000_0000},
         '{sse_pkg::ACT_INSERT, 32'h0000_0000, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_INSERT, 32'hffff_ffff, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_INSERT, 32'h0000_0001, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_INSERT, 32'h7fff_ffff, 1'b1, sse_pkg::RSP_DUPLICATE, 32'h7fff_ffff},
         '{sse_pkg::ACT_FIND,   32'h8000_0000, 1'b1, sse_pkg::RSP_FOUND,     32'h8000_0000},
         '{sse_pkg::ACT_FIND,   32'h7fff_fffe, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_LIST,   32'h0000_0000, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_DELETE, 32'h7fff_ffff, 1'b1, sse_pkg::RSP_DELETED,   32'h7fff_ffff},
         '{sse_pkg::ACT_DELETE, 32'h8000_0000, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_DELETE, 32'h8000_0000, 1'b1, sse_pkg::RSP_DEL_MISS,  32'h8000_0000},
         // value is ignored
         '{sse_pkg::ACT_LIST,   32'hffff_ffff, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_INSERT, 32'h5555_5555, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_INSERT, 32'haaaa_aaaa, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_FIND,   32'haaaa_aaaa, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_DELETE, 32'h0000_0000, 1'b0, sse_pkg::RSP_EMPTY,     32'h0},
         '{sse_pkg::ACT_LIST,   32'h1234_5678, 1'b0, sse_pkg::RSP_EMPTY,     32'h0}
      };

      // collision pool: extremes, a few small numbers, the rest anywhere
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL_SIZE; i++)
         value_pool[i] = (i % 3 == 0) ? $urandom_range(0, 64) - 32 : $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_req(dir_tab[i].act, dir_tab[i].value, dir_tab[i].typed,
                  dir_tab[i].status, dir_tab[i].item);

      // random phases cycle through fill toward full, mix, then drain toward empty
      n_random = 0;
      phase_idx = 0;
      while (n_random < RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 80);
         for (int k = 0; k < phase_len && n_random < RANDOM_ITEMS; k++) begin
            act = pick_action(phase_idx % 3);
            send_req(act, (act == sse_pkg::ACT_LIST) ? $urandom : pick_value(), 1'b0,
                     sse_pkg::RSP_EMPTY, 32'h0);
            n_random++;
            // long response hold-off, so the block backs up into the request side
            if (n_random == 60 || n_random == 290) hold_asked++;
         end
         phase_idx++;
      end
      req_tvalid <= 1'b0;

      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("sorted_set_engine: match");
      end else begin
         $display("sorted_set_engine: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/sse_pkg.sv
design/sse_ctrl.sv
design/sse_dp.sv
design/sorted_set_engine.sv
sim/sorted_set_engine_tb.sv
